FILE: sv/ucp_pkg.sv
// Shared widths, constants and item types for the unit normal pipeline.
package ucp_pkg;

    localparam int COMP_W    = 16;
    localparam int FRAC_BITS = 30;
    localparam int OUT_W     = 32;

    localparam int PROD_W    = 2 * COMP_W;
    localparam int CROSS_W   = 2 * COMP_W + 1;
    localparam int MAG_W     = 2 * COMP_W;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int M_W       = SQ_W + 2;
    localparam int R_W       = M_W + 1;
    localparam int DIV_STEPS = 2 * FRAC_BITS;
    localparam int Q_W       = DIV_STEPS + 1;
    localparam int ROOT_W    = FRAC_BITS + 1;
    localparam int SRC_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 4;

    typedef struct packed {
        logic signed [COMP_W-1:0] first_x;
        logic signed [COMP_W-1:0] first_y;
        logic signed [COMP_W-1:0] first_z;
        logic signed [COMP_W-1:0] second_x;
        logic signed [COMP_W-1:0] second_y;
        logic signed [COMP_W-1:0] second_z;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] unit_x;
        logic signed [OUT_W-1:0] unit_y;
        logic signed [OUT_W-1:0] unit_z;
        logic                    degenerate;
    } out_item_t;

    typedef struct packed {
        logic [R_W-1:0] rem;
        logic [Q_W-1:0] quo;
        logic           neg;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [2:0] lane;
        logic [M_W-1:0]  m;
        logic            degen;
    } div_item_t;

    typedef struct packed {
        logic [SRC_W-1:0]  src;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic              neg;
    } sqrt_lane_t;

    typedef struct packed {
        sqrt_lane_t [2:0] lane;
        logic             degen;
    } sqrt_item_t;

endpackage

FILE: sv/ucp_div_cell.sv
// One restoring division step for all three lanes, registered.
module ucp_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  ucp_pkg::div_item_t in_item,
    output logic              out_valid,
    output ucp_pkg::div_item_t out_item
);
    import ucp_pkg::*;

    logic      valid_reg;
    div_item_t item_reg;
    div_item_t item_next;

    always_comb
    begin
        logic [R_W-1:0] sh;
        logic           ge;
        item_next = in_item;
        for (int k = 0; k < 3; k++)
        begin
            sh = {in_item.lane[k].rem[R_W-2:0], 1'b0};
            ge = sh >= {1'b0, in_item.m};
            item_next.lane[k].rem = ge ? sh - {1'b0, in_item.m} : sh;
            item_next.lane[k].quo = {in_item.lane[k].quo[Q_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
endmodule

FILE: sv/ucp_sqrt_cell.sv
// One digit of the integer square root for all three lanes, registered.
module ucp_sqrt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ucp_pkg::sqrt_item_t in_item,
    output logic               out_valid,
    output ucp_pkg::sqrt_item_t out_item
);
    import ucp_pkg::*;

    logic       valid_reg;
    sqrt_item_t item_reg;
    sqrt_item_t item_next;

    always_comb
    begin
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        logic             ge;
        item_next = in_item;
        for (int k = 0; k < 3; k++)
        begin
            cur   = {in_item.lane[k].rem[REM_W-3:0], in_item.lane[k].src[SRC_W-1 -: 2]};
            trial = REM_W'({in_item.lane[k].root, 2'b01});
            ge    = cur >= trial;
            item_next.lane[k].rem  = ge ? cur - trial : cur;
            item_next.lane[k].root = {in_item.lane[k].root[ROOT_W-2:0], ge};
            item_next.lane[k].src  = {in_item.lane[k].src[SRC_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
endmodule

FILE: sv/unit_normal_from_cross_product_core.sv
// Top level: cross product, squared norm, and a chain of divide and root cells.
// Throughput is one item per cycle while the output is not blocked; the whole pipeline advances together.
// The chain freezes only while a finished item waits at the output.
// Reset clears every stage's valid bit; payload registers are not reset.
module unit_normal_from_cross_product_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  ucp_pkg::in_item_t src_data,
    output logic              dst_valid,
    input  logic              dst_stall,
    output ucp_pkg::out_item_t dst_data
);
    import ucp_pkg::*;

    // A single enable moves every stage; it drops only when the output
    // register holds an item that the consumer is not taking.
    logic en;
    assign en        = !(dst_valid && dst_stall);
    assign src_stall = !en;

    // Stage 1: the six partial products of the cross product.
    logic v1_reg;
    logic signed [PROD_W-1:0] p_reg [6];

    // Stage 2: cross components as sign and magnitude.
    logic v2_reg;
    logic [MAG_W-1:0] mag_reg [3];
    logic             neg2_reg [3];

    // Stage 3: squared magnitudes.
    logic v3_reg;
    logic [SQ_W-1:0] sq3_reg [3];
    logic            neg3_reg [3];

    // Stage 4: squared norm m.
    logic v4_reg;
    logic [SQ_W-1:0] sq4_reg [3];
    logic            neg4_reg [3];
    logic [M_W-1:0]  m_reg;

    // Stage 5: first quotient bit (sq never exceeds m), feeding the chain.
    logic      v5_reg;
    div_item_t d5_reg;
    div_item_t d5_next;

    logic signed [CROSS_W-1:0] xprod [3];

    always_comb
    begin
        xprod[0] = CROSS_W'(p_reg[0]) - CROSS_W'(p_reg[1]);
        xprod[1] = CROSS_W'(p_reg[2]) - CROSS_W'(p_reg[3]);
        xprod[2] = CROSS_W'(p_reg[4]) - CROSS_W'(p_reg[5]);
    end

    always_comb
    begin
        logic ge;
        d5_next.m     = m_reg;
        d5_next.degen = (m_reg == '0);
        for (int k = 0; k < 3; k++)
        begin
            ge = M_W'(sq4_reg[k]) >= m_reg;
            d5_next.lane[k].rem = ge ? '0 : R_W'(sq4_reg[k]);
            d5_next.lane[k].quo = Q_W'(ge);
            d5_next.lane[k].neg = neg4_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= src_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= src_data.first_y * src_data.second_z;
            p_reg[1] <= src_data.first_z * src_data.second_y;
            p_reg[2] <= src_data.first_z * src_data.second_x;
            p_reg[3] <= src_data.first_x * src_data.second_z;
            p_reg[4] <= src_data.first_x * src_data.second_y;
            p_reg[5] <= src_data.first_y * src_data.second_x;
            for (int k = 0; k < 3; k++)
            begin
                neg2_reg[k] <= xprod[k][CROSS_W-1];
                mag_reg[k]  <= xprod[k][CROSS_W-1] ? MAG_W'(-xprod[k]) : MAG_W'(xprod[k]);
                sq3_reg[k]  <= mag_reg[k] * mag_reg[k];
                neg3_reg[k] <= neg2_reg[k];
                sq4_reg[k]  <= sq3_reg[k];
                neg4_reg[k] <= neg3_reg[k];
            end
            m_reg  <= M_W'(sq3_reg[0]) + M_W'(sq3_reg[1]) + M_W'(sq3_reg[2]);
            d5_reg <= d5_next;
        end
    end

    // Long division: one quotient bit per cell, all three lanes side by side.
    logic      div_v   [DIV_STEPS+1];
    div_item_t div_bus [DIV_STEPS+1];

    assign div_v[0]   = v5_reg;
    assign div_bus[0] = d5_reg;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        ucp_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (div_v[i]),
            .in_item  (div_bus[i]),
            .out_valid(div_v[i+1]),
            .out_item (div_bus[i+1])
        );
    end

    // Square root of the quotient: one root bit per cell.
    logic       sq_v   [ROOT_W+1];
    sqrt_item_t sq_bus [ROOT_W+1];

    always_comb
    begin
        sq_bus[0].degen = div_bus[DIV_STEPS].degen;
        for (int k = 0; k < 3; k++)
        begin
            sq_bus[0].lane[k].src  = SRC_W'(div_bus[DIV_STEPS].lane[k].quo);
            sq_bus[0].lane[k].rem  = '0;
            sq_bus[0].lane[k].root = '0;
            sq_bus[0].lane[k].neg  = div_bus[DIV_STEPS].lane[k].neg;
        end
    end
    assign sq_v[0] = div_v[DIV_STEPS];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        ucp_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (sq_v[i]),
            .in_item  (sq_bus[i]),
            .out_valid(sq_v[i+1]),
            .out_item (sq_bus[i+1])
        );
    end

    // Output register: restore the sign, force zeros for a zero cross product.
    logic      out_valid_reg;
    out_item_t out_reg;
    out_item_t out_next;
    logic signed [OUT_W-1:0] comp [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (sq_bus[ROOT_W].degen)
                comp[k] = '0;
            else if (sq_bus[ROOT_W].lane[k].neg)
                comp[k] = -OUT_W'(sq_bus[ROOT_W].lane[k].root);
            else
                comp[k] = OUT_W'(sq_bus[ROOT_W].lane[k].root);
        end
        out_next.unit_x     = comp[0];
        out_next.unit_y     = comp[1];
        out_next.unit_z     = comp[2];
        out_next.degenerate = sq_bus[ROOT_W].degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= sq_v[ROOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign dst_valid = out_valid_reg;
    assign dst_data  = out_reg;

    localparam logic signed [OUT_W-1:0] ONE_Q = OUT_W'(1) << FRAC_BITS;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.degenerate |->
            dst_data.unit_x == '0 && dst_data.unit_y == '0 && dst_data.unit_z == '0)
        else $error("degenerate item carries nonzero components");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> dst_valid && dst_stall)
        else $error("input stalled without a blocked output item");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> dst_data.unit_x <= ONE_Q && dst_data.unit_x >= -ONE_Q &&
            dst_data.unit_y <= ONE_Q && dst_data.unit_y >= -ONE_Q &&
            dst_data.unit_z <= ONE_Q && dst_data.unit_z >= -ONE_Q)
        else $error("unit component beyond one");
endmodule
